@@ rtl/core/lbt_pkg.sv @@
// Shared types and constants for the LRU budget tracker.
// Used by the tracker engine and the top level; depends on nothing.
package lbt_pkg;

    localparam int KEY_W        = 16;
    localparam int BUDGET_W     = 7;
    localparam int CAPACITY_DEF = 64;
    localparam int MAX_RESULTS  = 64;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 7'd32;

    typedef enum logic {
        OP_TOUCH = 1'b0,
        OP_TRIM  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             last;
        logic             ovf;
    } t_result;

endpackage

@@ rtl/core/lbt_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; used for the key and age tables of the tracker.
module lbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/lbt_engine.sv @@
// Sequencer and slot unit of the LRU budget tracker: walks the key and age
// tables one slot per cycle to look up, age and evict entries. Uses lbt_pkg.
module lbt_engine #(
    parameter int CAPACITY = lbt_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lbt_pkg::t_op                  i_op,
    input  logic [lbt_pkg::KEY_W-1:0]     i_key,
    input  logic [lbt_pkg::BUDGET_W-1:0]  i_budget,
    input  logic                          i_out_free,
    output logic                          o_busy,
    output lbt_pkg::t_result              o_res,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [lbt_pkg::KEY_W-1:0]     i_key_rd,
    input  logic [AW-1:0]                 i_age_rd,
    output logic                          o_key_we,
    output logic [AW-1:0]                 o_key_wr_addr,
    output logic [lbt_pkg::KEY_W-1:0]     o_key_wr_data,
    output logic                          o_age_we,
    output logic [AW-1:0]                 o_age_wr_addr,
    output logic [AW-1:0]                 o_age_wr_data
);
    import lbt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > BUDGET_W) ? CW : BUDGET_W) + 1;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [CW-1:0]        r_count, n_count;
    logic [CAPACITY-1:0]  r_valid, n_valid;
    logic [CW-1:0]        r_rd_ptr, n_rd_ptr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_pend_idx, n_pend_idx;
    logic                 r_hit_found, n_hit_found;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    logic [AW-1:0]        r_hit_age, n_hit_age;
    logic                 r_free_found, n_free_found;
    logic [AW-1:0]        r_free_idx, n_free_idx;
    logic [AW-1:0]        r_old_idx, n_old_idx;
    logic [KEY_W-1:0]     r_old_key, n_old_key;
    logic [AW-1:0]        r_target, n_target;
    logic [AW-1:0]        r_limit, n_limit;
    logic                 r_age_all, n_age_all;
    logic                 r_insert, n_insert;
    logic [KEY_W-1:0]     r_res_key, n_res_key;
    logic                 r_res_last, n_res_last;
    logic                 r_res_ovf, n_res_ovf;
    logic                 r_ret_age, n_ret_age;
    logic [RES_CNT_W-1:0] r_n, n_n;

    logic          walking;
    logic          issuing;
    logic          walk_end;
    logic          walk_start;
    logic          full;
    logic          over_budget;
    logic          last_trim;
    logic          slot_valid;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] old_age;

    always_comb begin
        walking     = (r_state == ST_SCAN) || (r_state == ST_AGE);
        issuing     = walking && (r_rd_ptr != CW'(CAPACITY));
        walk_end    = walking && (r_rd_ptr == CW'(CAPACITY)) && !r_pend;
        full        = (r_count == CW'(CAPACITY));
        over_budget = EW'(r_count) > EW'(i_budget);
        last_trim   = (EW'(r_count) <= EW'(i_budget) + EW'(1))
                      || (r_n == RES_CNT_W'(MAX_RESULTS - 1));
        slot_valid  = r_valid[r_pend_idx];
        cnt_m1      = r_count - CW'(1);
        old_age     = cnt_m1[AW-1:0];
    end

    assign walk_start = ((n_state == ST_SCAN) || (n_state == ST_AGE)) && (n_state != r_state);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && ((i_op == OP_TOUCH) || over_budget)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (walk_end) begin
                    if ((r_op == OP_TOUCH) && (r_hit_found || !full)) begin
                        n_state = ST_AGE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_AGE: begin
                if (walk_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    if (r_ret_age) begin
                        n_state = ST_AGE;
                    end else if (r_res_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_rd_addr     = r_rd_ptr[AW-1:0];
        o_res.valid   = (r_state == ST_EMIT) && i_out_free;
        o_res.key     = r_res_key;
        o_res.last    = r_res_last;
        o_res.ovf     = r_res_ovf;
        o_key_we      = (r_state == ST_AGE) && walk_end && r_insert;
        o_key_wr_addr = r_target;
        o_key_wr_data = r_key;
        o_age_we      = (r_state == ST_AGE) && r_pend;
        o_age_wr_addr = r_pend_idx;
        if (r_pend_idx == r_target) begin
            o_age_wr_data = '0;
        end else if (slot_valid && (r_age_all || (i_age_rd < r_limit))) begin
            o_age_wr_data = i_age_rd + AW'(1);
        end else begin
            o_age_wr_data = i_age_rd;
        end
    end

    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_count      = r_count;
        n_valid      = r_valid;
        n_rd_ptr     = r_rd_ptr;
        n_pend       = issuing;
        n_pend_idx   = r_rd_ptr[AW-1:0];
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_age    = r_hit_age;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_old_idx    = r_old_idx;
        n_old_key    = r_old_key;
        n_target     = r_target;
        n_limit      = r_limit;
        n_age_all    = r_age_all;
        n_insert     = r_insert;
        n_res_key    = r_res_key;
        n_res_last   = r_res_last;
        n_res_ovf    = r_res_ovf;
        n_ret_age    = r_ret_age;
        n_n          = r_n;

        if ((r_state == ST_IDLE) && i_start) begin
            n_op  = i_op;
            n_key = i_key;
            n_n   = '0;
        end

        if (issuing) begin
            n_rd_ptr = r_rd_ptr + CW'(1);
        end

        if ((r_state == ST_SCAN) && r_pend) begin
            if (slot_valid && (i_key_rd == r_key) && (r_op == OP_TOUCH)) begin
                n_hit_found = 1'b1;
                n_hit_idx   = r_pend_idx;
                n_hit_age   = i_age_rd;
            end
            if (!slot_valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_pend_idx;
            end
            if (slot_valid && (i_age_rd == old_age)) begin
                n_old_idx = r_pend_idx;
                n_old_key = i_key_rd;
            end
        end

        if ((r_state == ST_SCAN) && walk_end) begin
            if (r_op == OP_TOUCH) begin
                if (r_hit_found) begin
                    n_target  = r_hit_idx;
                    n_limit   = r_hit_age;
                    n_age_all = 1'b0;
                    n_insert  = 1'b0;
                end else if (!full) begin
                    n_target  = r_free_idx;
                    n_age_all = 1'b1;
                    n_insert  = 1'b1;
                end else begin
                    n_target            = r_old_idx;
                    n_age_all           = 1'b1;
                    n_insert            = 1'b1;
                    n_res_key           = r_old_key;
                    n_res_last          = 1'b1;
                    n_res_ovf           = 1'b1;
                    n_ret_age           = 1'b1;
                    n_valid[r_old_idx]  = 1'b0;
                    n_count             = cnt_m1;
                end
            end else begin
                n_res_key          = r_old_key;
                n_res_last         = last_trim;
                n_res_ovf          = 1'b0;
                n_ret_age          = 1'b0;
                n_valid[r_old_idx] = 1'b0;
                n_count            = cnt_m1;
                n_n                = r_n + RES_CNT_W'(1);
            end
        end

        if ((r_state == ST_AGE) && walk_end && r_insert) begin
            n_valid[r_target] = 1'b1;
            n_count           = r_count + CW'(1);
        end

        if (walk_start) begin
            n_rd_ptr     = '0;
            n_pend       = 1'b0;
            n_hit_found  = 1'b0;
            n_free_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_valid      <= '0;
            r_rd_ptr     <= '0;
            r_pend       <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_n          <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_valid      <= n_valid;
            r_rd_ptr     <= n_rd_ptr;
            r_pend       <= n_pend;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            r_n          <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_pend_idx <= n_pend_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_age  <= n_hit_age;
        r_free_idx <= n_free_idx;
        r_old_idx  <= n_old_idx;
        r_old_key  <= n_old_key;
        r_target   <= n_target;
        r_limit    <= n_limit;
        r_age_all  <= n_age_all;
        r_insert   <= n_insert;
        r_res_key  <= n_res_key;
        r_res_last <= n_res_last;
        r_res_ovf  <= n_res_ovf;
        r_ret_age  <= n_ret_age;
    end

endmodule

@@ rtl/core/lru_budget_tracker.sv @@
// A touch is busy for two table walks, a scan and an aging walk; an overflow touch
// also hands over its evicted word between them and waits while the output is held.
// A trim is busy for one scan walk per evicted word plus output waits, and a trim that
// evicts nothing ends in its accepting cycle. One word is worked on at a time; the walks
// share one read address for the key and age tables.
// Reset is synchronous: the table is empty and the budget is 32 right after it.
module lru_budget_tracker #(
    parameter int CAPACITY = lbt_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [lbt_pkg::KEY_W-1:0]    i_node_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lbt_pkg::KEY_W-1:0]    o_evicted_key,
    output logic                         o_last_eviction,
    output logic                         o_overflow,
    input  logic                         i_cfg_wr_en,
    input  logic [lbt_pkg::BUDGET_W-1:0] i_cfg_wr_data
);
    import lbt_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [BUDGET_W-1:0] r_budget;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_key;
    logic                r_out_last;
    logic                r_out_ovf;

    logic             busy;
    logic             start;
    logic             out_free;
    t_result          res;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] key_rd;
    logic [AW-1:0]    age_rd;
    logic             key_we;
    logic [AW-1:0]    key_wr_addr;
    logic [KEY_W-1:0] key_wr_data;
    logic             age_we;
    logic [AW-1:0]    age_wr_addr;
    logic [AW-1:0]    age_wr_data;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    lbt_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_op          (t_op'(i_op)),
        .i_key         (i_node_key),
        .i_budget      (r_budget),
        .i_out_free    (out_free),
        .o_busy        (busy),
        .o_res         (res),
        .o_rd_addr     (rd_addr),
        .i_key_rd      (key_rd),
        .i_age_rd      (age_rd),
        .o_key_we      (key_we),
        .o_key_wr_addr (key_wr_addr),
        .o_key_wr_data (key_wr_data),
        .o_age_we      (age_we),
        .o_age_wr_addr (age_wr_addr),
        .o_age_wr_data (age_wr_data)
    );

    lbt_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (key_wr_addr),
        .i_wr_data (key_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_rd)
    );

    lbt_ram #(
        .WIDTH(AW),
        .DEPTH(CAPACITY)
    ) u_age_ram (
        .i_clk     (i_clk),
        .i_we      (age_we),
        .i_wr_addr (age_wr_addr),
        .i_wr_data (age_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (age_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= BUDGET_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_budget <= i_cfg_wr_data;
            end
            if (res.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_key  <= res.key;
            r_out_last <= res.last;
            r_out_ovf  <= res.ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_evicted_key   = r_out_key;
    assign o_last_eviction = r_out_last;
    assign o_overflow      = r_out_ovf;

`ifndef SYNTH
    // An accepted touch word always keeps the block busy for at least the next cycle.
    a_busy_after_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (t_op'(i_op) == OP_TOUCH)) |=> o_in_stall)
        else $error("touch word accepted but block not busy afterwards");

    // A forced eviction is always the only and final word of its touch.
    a_ovf_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> o_last_eviction)
        else $error("overflow eviction not marked as last");

    // A result word is only produced while the block is working on an item.
    a_res_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> busy)
        else $error("result word produced while idle");
`endif

endmodule

@@ tb/sv/lbt_checker.sv @@
`timescale 1ns / 100ps
// Checker for the LRU budget tracker. It follows the word, result and budget ports,
// keeps its own recency table, and compares every evicted word in order of arrival.
// It depends on lbt_pkg for the operation codes and the field widths.
module lbt_checker #(
    parameter int CAPACITY = lbt_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_op,
    input  logic [lbt_pkg::KEY_W-1:0]    i_node_key,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [lbt_pkg::KEY_W-1:0]    i_evicted_key,
    input  logic                         i_last_eviction,
    input  logic                         i_overflow,
    input  logic                         i_cfg_wr_en,
    input  logic [lbt_pkg::BUDGET_W-1:0] i_cfg_wr_data,
    output int                           o_mismatches,
    output int                           o_pending_words
);
    import lbt_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             ovf;
    } t_evict_word;

    logic [KEY_W-1:0]    slot_key  [CAPACITY];
    bit                  slot_used [CAPACITY];
    int unsigned         slot_rank [CAPACITY];
    int unsigned         used_count;
    logic [BUDGET_W-1:0] budget;
    t_evict_word         expected_evictions[$];
    t_evict_word         want;
    int                  mismatch_total = 0;

    function automatic int oldest_slot();
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && slot_rank[i] == used_count - 1) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic evict_oldest(input logic last, input logic ovf);
        int          s;
        t_evict_word w;
        s = oldest_slot();
        if (s >= 0) begin
            w.key = slot_key[s];
            w.last = last;
            w.ovf = ovf;
            expected_evictions = {expected_evictions, w};
            slot_used[s] = 1'b0;
            used_count--;
        end
    endtask

    task automatic predict_evictions(input t_op kind, input logic [KEY_W-1:0] key);
        int          hit;
        int          free_slot;
        int          n;
        int unsigned hit_rank;
        hit = -1;
        free_slot = -1;
        n = 0;
        if (kind == OP_TOUCH) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (hit < 0 && slot_used[i] && slot_key[i] == key) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                hit_rank = slot_rank[hit];
                for (int i = 0; i < CAPACITY; i++) begin
                    if (slot_used[i] && slot_rank[i] < hit_rank) begin
                        slot_rank[i]++;
                    end
                end
                slot_rank[hit] = 0;
            end else begin
                // A new key into a full table pushes out the least recent entry first.
                if (used_count >= CAPACITY) begin
                    evict_oldest(1'b1, 1'b1);
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (free_slot < 0 && !slot_used[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i]) begin
                            slot_rank[i]++;
                        end
                    end
                    slot_key[free_slot] = key;
                    slot_used[free_slot] = 1'b1;
                    slot_rank[free_slot] = 0;
                    used_count++;
                end
            end
        end else begin
            while (used_count > budget && n < MAX_RESULTS) begin
                n++;
                evict_oldest((used_count - 1 <= budget) || (n == MAX_RESULTS), 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_key[i] = '0;
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            used_count = 0;
            budget = BUDGET_RESET;
            expected_evictions.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_evictions.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("%0t: unexpected word: key %h last %b overflow %b",
                                 $time, i_evicted_key, i_last_eviction, i_overflow);
                    end
                end else begin
                    want = expected_evictions.pop_front();
                    if (i_evicted_key !== want.key || i_last_eviction !== want.last ||
                            i_overflow !== want.ovf) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("%0t: word mismatch: expected key %h last %b overflow %b",
                                     $time, want.key, want.last, want.ovf);
                            $display("    got key %h last %b overflow %b",
                                     i_evicted_key, i_last_eviction, i_overflow);
                        end
                    end
                end
            end
            if (i_cfg_wr_en) begin
                budget = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_evictions(t_op'(i_op), i_node_key);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending_words <= expected_evictions.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the LRU budget tracker testbench: clock, reset, stimulus, stalls and verdict.
// It depends on lbt_pkg, on lru_budget_tracker and on lbt_checker, which does the checking.
module tb;
    import lbt_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
    localparam int PHASE_WORDS   = 50;
    localparam int PHASE_COUNT   = 8;
    localparam int HEAVY_PCT     = 61;
    localparam int LIGHT_PCT     = 6;
    localparam int CYCLE_LIMIT   = 8_000_000;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_op                 op = OP_TOUCH;
    logic [KEY_W-1:0]    node_key = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KEY_W-1:0]    evicted_key;
    logic                last_eviction;
    logic                overflow;
    logic                cfg_wr_en = 1'b0;
    logic [BUDGET_W-1:0] cfg_wr_data = '0;

    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  cycle_count = 0;
    int                  mismatches;
    int                  pending_words;
    int                  phase_budget [PHASE_COUNT];
    t_idle_mode          mode;
    logic [KEY_W-1:0]    fresh_key;

    lru_budget_tracker #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (op),
        .i_node_key     (node_key),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_evicted_key  (evicted_key),
        .o_last_eviction(last_eviction),
        .o_overflow     (overflow),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    lbt_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (op),
        .i_node_key     (node_key),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_evicted_key  (evicted_key),
        .i_last_eviction(last_eviction),
        .i_overflow     (overflow),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_mismatches   (mismatches),
        .o_pending_words(pending_words)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_budget_tracker regression: fail");
            $finish;
        end
    end

    task automatic push_word(input t_op kind, input logic [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        node_key <= key;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(input logic [BUDGET_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Most touches use fresh keys or keys a little behind them, so the table fills,
    // hits recent entries and overflows; a few keys are fully random.
    task automatic run_random(input int count);
        int               r;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            key = KEY_W'($urandom);
            if (r < 8) begin
                push_word(OP_TRIM, key);
            end else if (r < 58) begin
                push_word(OP_TOUCH, fresh_key);
                fresh_key++;
            end else if (r < 93) begin
                push_word(OP_TOUCH, fresh_key - KEY_W'($urandom_range(1, 70)));
            end else begin
                push_word(OP_TOUCH, key);
            end
        end
    endtask

    initial begin
        fresh_key = KEY_W'($urandom);
        phase_budget = '{64, 64, 63, 64, $urandom_range(0, 64), 1, 0, 32};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_word(OP_TRIM, 16'hFFFF);
        push_word(OP_TOUCH, 16'h0000);
        push_word(OP_TOUCH, 16'hFFFF);
        push_word(OP_TOUCH, 16'h0000);
        push_word(OP_TOUCH, 16'h5555);
        push_word(OP_TOUCH, 16'hAAAA);
        push_word(OP_TOUCH, 16'hFFFF);
        push_word(OP_TRIM, 16'h0000);
        wait_idle();
        write_budget(BUDGET_W'(2));
        push_word(OP_TRIM, 16'h0000);
        push_word(OP_TOUCH, 16'h8000);
        push_word(OP_TOUCH, 16'h7FFF);
        push_word(OP_TRIM, 16'hFFFF);
        wait_idle();
        write_budget(BUDGET_W'(0));
        push_word(OP_TRIM, 16'h0000);
        push_word(OP_TRIM, 16'h0000);
        push_word(OP_TOUCH, 16'h1234);
        push_word(OP_TOUCH, 16'h1234);
        push_word(OP_TRIM, 16'h1234);
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_budget(BUDGET_W'(phase_budget[p]));
            mode = t_idle_mode'(p % 4);
            send_idle_pct = (mode == IDLE_SENDER) ? HEAVY_PCT :
                            (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
            stall_pct = (mode == IDLE_RECEIVER) ? HEAVY_PCT :
                        (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
            run_random(PHASE_WORDS);
            wait_idle();
        end

        if (mismatches == 0 && pending_words == 0) begin
            $display("lru_budget_tracker regression: pass");
        end else begin
            $display("lru_budget_tracker regression: fail");
        end
        $finish;
    end

endmodule
